// ----- src/rtc_pkg.sv -----
// rtc_pkg: shared types, calendar constants and month-length lookup
// for the real-time clock and calendar; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rtc_pkg;

  typedef struct packed {
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
  } rtc_time_t;

  localparam logic [5:0]  SecLast    = 6'd59;
  localparam logic [5:0]  MinLast    = 6'd59;
  localparam logic [4:0]  HourLast   = 5'd23;
  localparam logic [3:0]  MonthLast  = 4'd12;
  localparam logic [3:0]  MonthFeb   = 4'd2;
  localparam logic [4:0]  DaysLong   = 5'd31;

  // floor(y / 25) = (y * Recip25) >> RecipShift for every 16-bit y
  localparam logic [32:0] Recip25    = 33'd83887;
  localparam int          RecipShift = 21;

  localparam logic [4:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  localparam rtc_time_t TimeReset = '{
    hours: 5'd0, minutes: 6'd0, seconds: 6'd0,
    day: 5'd1, month: 4'd1, year: 16'd0
  };

  function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                               input logic       leap);
    logic [3:0] idx;
    logic [4:0] len;
    idx = month - 4'd1;
    if (month == 4'd0 || month > MonthLast) begin
      len = DaysLong;
    end else begin
      len = MonthLen[idx];
      if (month == MonthFeb && leap) begin
        len = len + 5'd1;
      end
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- src/rtc_time_and_calendar.sv -----
// rtc_time_and_calendar: real-time clock and Gregorian calendar top level
// input register, rtc_next update logic, result register; uses rtc_pkg
//
//  channel | ports                                    | direction
//  in      | in_valid in_ready in_func in_load_*      | request in
//  out     | out_valid out_ready out_hours .. new_day | result out
//
//  one request per cycle sustained while out_ready is high; a request passes the
//  input register and the result register, and the state update is a single pass
//  through rtc_next (leap test multiply); reset gives 00:00:00, day 1, month 1,
//  year 0, both stages empty; a stalled result holds; the input stage still takes
//  a request while it is empty, or while the result stage is empty or being drained in the same cycle
`timescale 1ns / 1ps
`default_nettype none

module rtc_time_and_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [4:0]  in_load_hours,
  input  logic [5:0]  in_load_minutes,
  input  logic [5:0]  in_load_seconds,
  input  logic [4:0]  in_load_day,
  input  logic [3:0]  in_load_month,
  input  logic [15:0] in_load_year,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_hours,
  output logic [5:0]  out_minutes,
  output logic [5:0]  out_seconds,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month_number,
  output logic [15:0] out_year_number,
  output logic        out_new_day
);
  import rtc_pkg::*;

  logic      in_valid_r;
  logic      func_r;
  rtc_time_t load_r;
  rtc_time_t time_r;
  rtc_time_t time_nxt;
  logic      new_day_nxt;
  logic      out_valid_r;
  rtc_time_t res_r;
  logic      new_day_r;
  logic      advance;
  logic      step;

  assign advance  = !out_valid_r || out_ready;
  assign step     = advance && in_valid_r;
  assign in_ready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= in_func;
      load_r <= '{hours: in_load_hours, minutes: in_load_minutes,
                  seconds: in_load_seconds, day: in_load_day,
                  month: in_load_month, year: in_load_year};
    end
  end

  rtc_next u_next (
    .cur     (time_r),
    .func    (func_r),
    .load    (load_r),
    .nxt     (time_nxt),
    .new_day (new_day_nxt)
  );

  // clock state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= TimeReset;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        time_r <= time_nxt;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r     <= time_nxt;
      new_day_r <= new_day_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hours        = res_r.hours;
  assign out_minutes      = res_r.minutes;
  assign out_seconds      = res_r.seconds;
  assign out_day_of_month = res_r.day;
  assign out_month_number = res_r.month;
  assign out_year_number  = res_r.year;
  assign out_new_day      = new_day_r;

  // a load lands in the clock state unchanged
  a_load_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (step && func_r) |=> (time_r == $past(load_r)))
    else $error("load not stored");

  // midnight crossing leaves the time of day at zero
  a_new_day_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_new_day) |->
      (out_hours == 5'd0 && out_minutes == 6'd0 && out_seconds == 6'd0))
    else $error("new day with non-zero time");

  // a valid result always mirrors the clock state
  a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r == time_r))
    else $error("result differs from clock state");

  // a plain tick below the seconds limit touches only the seconds
  a_tick_seconds: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !func_r && time_r.seconds < SecLast) |=>
      (time_r.seconds == $past(time_r.seconds) + 6'd1 &&
       time_r.minutes == $past(time_r.minutes) && !new_day_r))
    else $error("tick disturbed more than seconds");

  // a result appears only after a request sat in the input stage
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid_r))
    else $error("result without request");

endmodule

`default_nettype wire

// ----- src/rtc_next.sv -----
// rtc_next: next time and date for one request, either a load or a
// one-second tick with the Gregorian leap rule; uses rtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtc_next (
  input  rtc_pkg::rtc_time_t cur,
  input  logic               func,
  input  rtc_pkg::rtc_time_t load,
  output rtc_pkg::rtc_time_t nxt,
  output logic               new_day
);
  import rtc_pkg::*;

  logic [32:0] prod;
  logic [11:0] quot;
  logic [16:0] quot25;
  logic        div25;
  logic        leap;
  logic [4:0]  month_len;

  // divisibility by 25 through reciprocal multiply
  assign prod   = {17'd0, cur.year} * Recip25;
  assign quot   = prod[RecipShift +: 12];
  assign quot25 = {1'b0, quot, 4'd0} + {2'b0, quot, 3'd0} + {5'd0, quot};
  assign div25  = (quot25 == {1'b0, cur.year});

  assign leap      = (cur.year[1:0] == 2'd0) && (!div25 || cur.year[3:0] == 4'd0);
  assign month_len = days_in_month(cur.month, leap);

  always_comb begin
    nxt     = cur;
    new_day = 1'b0;
    if (func) begin
      nxt = load;
    end else if (cur.seconds < SecLast) begin
      nxt.seconds = cur.seconds + 6'd1;
    end else begin
      nxt.seconds = 6'd0;
      if (cur.minutes < MinLast) begin
        nxt.minutes = cur.minutes + 6'd1;
      end else begin
        nxt.minutes = 6'd0;
        if (cur.hours < HourLast) begin
          nxt.hours = cur.hours + 5'd1;
        end else begin
          nxt.hours = 5'd0;
          new_day   = 1'b1;
          if (cur.day < month_len) begin
            nxt.day = cur.day + 5'd1;
          end else begin
            nxt.day = 5'd1;
            if (cur.month >= MonthLast) begin
              nxt.month = 4'd1;
              nxt.year  = cur.year + 16'd1;
            end else begin
              nxt.month = cur.month + 4'd1;
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire
